// ----- sv/nlsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nlsc_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package nlsc_pkg;

    localparam int unsigned DATA_W        = 8;
    localparam int unsigned LEN_W         = 32;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 3;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned SC_BYTES      = 4;
    localparam int unsigned SC_CNT_W      = 2;
    localparam int unsigned PREFIX_MAX    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_ENABLE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_FIELD_BYTES = 1'd1;

    localparam logic [DATA_W-1:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [DATA_W-1:0] SC_LAST_BYTE = 8'h01;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              first_of_sample;
        logic [LEN_W-1:0]  sample_length;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              last_of_run;
        logic              end_of_sample;
    } out_item_t;

    // one queued command: either a copied byte or a whole start code
    typedef struct packed {
        logic              start_code;
        logic [DATA_W-1:0] data;
        logic              eos;
    } cmd_t;

endpackage

// ----- sv/nlsc_front.sv -----
// ----------------------------------------------------------------------------
// nlsc_front
// Accepts input bytes, tracks sample and unit state, issues output commands.
// ----------------------------------------------------------------------------
module nlsc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [nlsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nlsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  nlsc_pkg::in_item_t                in_item,
    output logic                              push,
    output nlsc_pkg::cmd_t                    push_cmd
);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_PAYLOAD,
        PH_REST
    } phase_t;

    localparam int unsigned LW = nlsc_pkg::LEN_W;
    localparam int unsigned DW = nlsc_pkg::DATA_W;

    logic                                 convert_enable_reg;
    logic [nlsc_pkg::CFG_DATA_W-1:0]      length_field_bytes_reg;

    phase_t          phase_reg, phase_next;
    logic [1:0]      psn_reg, psn_next;
    logic [LW-1:0]   acc_reg, acc_next;
    logic [LW-1:0]   pl_reg, pl_next;
    logic [LW-1:0]   sbl_reg, sbl_next;
    logic [LW-1:0]   total_reg, total_next;

    logic [2:0]      prefix_size;
    logic            accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        if (length_field_bytes_reg == 3'd0) begin
            prefix_size = 3'd1;
        end else if (length_field_bytes_reg > 3'(nlsc_pkg::PREFIX_MAX)) begin
            prefix_size = 3'(nlsc_pkg::PREFIX_MAX);
        end else begin
            prefix_size = length_field_bytes_reg;
        end
    end

    always_comb begin
        logic          eos;
        logic          restart;
        logic [LW-1:0] sbl_eff;
        logic [LW-1:0] sbl_dec;
        logic [LW-1:0] acc_shift;
        logic [LW-1:0] pl_dec;
        logic [LW-1:0] clamp;

        phase_next = phase_reg;
        psn_next   = psn_reg;
        acc_next   = acc_reg;
        pl_next    = pl_reg;
        sbl_next   = sbl_reg;
        total_next = total_reg;
        push       = 1'b0;
        push_cmd   = '0;
        restart    = 1'b0;

        sbl_eff   = in_item.first_of_sample ? in_item.sample_length : sbl_reg;
        sbl_dec   = sbl_eff - LW'(1);
        eos       = (sbl_eff == LW'(1));
        acc_shift = {acc_reg[LW-DW-1:0], in_item.data_byte};
        pl_dec    = (pl_reg != '0) ? pl_reg - LW'(1) : pl_reg;
        clamp     = (acc_shift < sbl_dec) ? acc_shift : sbl_dec;

        if (accept) begin
            if (in_item.first_of_sample) begin
                total_next = in_item.sample_length;
                sbl_next   = in_item.sample_length;
                phase_next = PH_LEN;
                psn_next   = '0;
                acc_next   = '0;
                pl_next    = '0;
            end
            if (sbl_eff != '0) begin
                sbl_next      = sbl_dec;
                push_cmd.eos  = eos;
                push_cmd.data = in_item.data_byte;
                if (!convert_enable_reg) begin
                    push    = 1'b1;
                    restart = eos;
                end else if (in_item.first_of_sample || phase_reg == PH_LEN) begin
                    // a new sample always starts in the length field
                    if ({1'b0, (in_item.first_of_sample ? 2'd0 : psn_reg)} + 3'd1
                            < prefix_size) begin
                        psn_next = (in_item.first_of_sample ? 2'd0 : psn_reg) + 2'd1;
                        acc_next = in_item.first_of_sample
                                 ? LW'(in_item.data_byte) : acc_shift;
                    end else begin
                        push                = 1'b1;
                        push_cmd.start_code = 1'b1;
                        psn_next            = '0;
                        acc_next            = '0;
                        if (in_item.first_of_sample) begin
                            // one-byte prefix on the sample's first byte
                            if (in_item.data_byte == '0 ||
                                    LW'(in_item.data_byte) > in_item.sample_length) begin
                                phase_next = PH_REST;
                            end else begin
                                pl_next = (LW'(in_item.data_byte) < sbl_dec)
                                        ? LW'(in_item.data_byte) : sbl_dec;
                                phase_next = ((LW'(in_item.data_byte) < sbl_dec
                                        ? LW'(in_item.data_byte) : sbl_dec) != '0)
                                        ? PH_PAYLOAD : PH_LEN;
                            end
                        end else if (acc_shift == '0 || acc_shift > total_reg) begin
                            phase_next = PH_REST;
                        end else begin
                            pl_next    = clamp;
                            phase_next = (clamp != '0) ? PH_PAYLOAD : PH_LEN;
                        end
                    end
                    restart = eos;
                end else begin
                    push = 1'b1;
                    if (phase_reg == PH_PAYLOAD) begin
                        pl_next = pl_dec;
                        restart = (pl_dec == '0);
                    end
                    restart = restart || eos;
                end
                if (restart) begin
                    phase_next = PH_LEN;
                    psn_next   = '0;
                    acc_next   = '0;
                    pl_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            convert_enable_reg     <= 1'b1;
            length_field_bytes_reg <= nlsc_pkg::CFG_DATA_W'(nlsc_pkg::PREFIX_MAX);
            phase_reg              <= PH_LEN;
            psn_reg                <= '0;
            acc_reg                <= '0;
            pl_reg                 <= '0;
            sbl_reg                <= '0;
            total_reg              <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    nlsc_pkg::CFG_CONVERT_ENABLE: begin
                        convert_enable_reg <= cfg_wdata[0];
                    end
                    nlsc_pkg::CFG_LENGTH_FIELD_BYTES: begin
                        length_field_bytes_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            phase_reg <= phase_next;
            psn_reg   <= psn_next;
            acc_reg   <= acc_next;
            pl_reg    <= pl_next;
            sbl_reg   <= sbl_next;
            total_reg <= total_next;
        end
    end

endmodule

// ----- sv/nlsc_fifo.sv -----
// ----------------------------------------------------------------------------
// nlsc_fifo
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module nlsc_fifo #(
    parameter int unsigned DEPTH = nlsc_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  nlsc_pkg::cmd_t  push_cmd,
    output logic            not_full,
    input  logic            pop,
    output logic            head_valid,
    output nlsc_pkg::cmd_t  head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    nlsc_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign not_full   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/nlsc_back.sv -----
// ----------------------------------------------------------------------------
// nlsc_back
// Expands queued commands into output bytes behind an output register.
// ----------------------------------------------------------------------------
module nlsc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  nlsc_pkg::cmd_t       head_cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output nlsc_pkg::out_item_t  m_item
);

    localparam int unsigned CW = nlsc_pkg::SC_CNT_W;

    logic                 m_valid_reg;
    nlsc_pkg::out_item_t  m_item_reg, m_item_next;
    logic [CW-1:0]        cnt_reg;
    logic                 load;
    logic                 cmd_last;

    assign load     = head_valid && (!m_valid_reg || m_ready);
    assign cmd_last = !head_cmd.start_code || (cnt_reg == CW'(nlsc_pkg::SC_BYTES - 1));
    assign pop      = load && cmd_last;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_comb begin
        m_item_next.last_of_run   = cmd_last;
        m_item_next.end_of_sample = cmd_last && head_cmd.eos;
        if (!head_cmd.start_code) begin
            m_item_next.out_byte = head_cmd.data;
        end else if (cmd_last) begin
            m_item_next.out_byte = nlsc_pkg::SC_LAST_BYTE;
        end else begin
            m_item_next.out_byte = nlsc_pkg::SC_ZERO_BYTE;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= m_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                cnt_reg     <= cmd_last ? '0 : cnt_reg + CW'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/nal_length_prefix_to_start_code.sv -----
// ----------------------------------------------------------------------------
// nal_length_prefix_to_start_code
// Converts length-prefixed NAL units to start-code byte streams.
// ----------------------------------------------------------------------------
// The s_ channel takes one sample byte per item, with first_of_sample and the
// sample's length on its first byte. The m_ channel gives output bytes;
// last_of_run marks the last byte caused by one input item and end_of_sample
// the byte that closes the sample.
// Prefix bytes and out-of-sample bytes give no output. A completed prefix
// gives the four-byte start code; other bytes give one output byte each.
// With the queue empty, an item's first output goes through a queue entry
// and then the output register before it is on m_.
// Throughput: one input item per cycle while the command queue has room; the
// back end sends one byte per cycle while m_ready allows, so a start code holds it
// for its four bytes and the queue (QUEUE_DEPTH entries) absorbs that burst.
// A stalled m_ready holds the output register; the queue then fills and
// s_ready drops once it is full.
// Reset (aresetn low, synchronous) empties the queue and the output, clears
// all unit and sample state and loads convert_enable = 1 and a four-byte
// length field. cfg_we writes a register; write it only idle.
// ----------------------------------------------------------------------------
module nal_length_prefix_to_start_code #(
    parameter int unsigned QUEUE_DEPTH = nlsc_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [nlsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nlsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  nlsc_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output nlsc_pkg::out_item_t              m_item
);

    logic            push;
    nlsc_pkg::cmd_t  push_cmd;
    logic            pop;
    logic            head_valid;
    nlsc_pkg::cmd_t  head_cmd;

    nlsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    nlsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .not_full   (s_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    nlsc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

// ----- tb/nlsc_stream_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nlsc_stream_checker
// Watches the converter's ports, predicts the start-code byte stream from
// every accepted input item and compares each output item in order.
// ----------------------------------------------------------------------------
module nlsc_stream_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [nlsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nlsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  nlsc_pkg::in_item_t               s_item,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  nlsc_pkg::out_item_t              m_item,
    output int                               fail_count,
    output int                               pending
);

    typedef enum logic [1:0] {
        GATHER_PREFIX,
        COPY_PAYLOAD,
        COPY_REST
    } unit_phase_t;

    logic                        conv_on;
    logic [2:0]                  prefix_cfg;
    unit_phase_t                 phase;
    logic [1:0]                  prefix_seen;
    logic [nlsc_pkg::LEN_W-1:0]  len_acc;
    logic [nlsc_pkg::LEN_W-1:0]  payload_left;
    logic [nlsc_pkg::LEN_W-1:0]  sample_left;
    logic [nlsc_pkg::LEN_W-1:0]  sample_total;
    nlsc_pkg::out_item_t         expected_bytes[$];
    int                          errors = 0;

    function automatic void restart_unit();
        phase        = GATHER_PREFIX;
        prefix_seen  = 2'd0;
        len_acc      = '0;
        payload_left = '0;
    endfunction

    // out-of-range sizes saturate to 1 and 4
    function automatic int prefix_bytes();
        if (prefix_cfg < 3'd1) return 1;
        if (prefix_cfg > 3'd4) return 4;
        return int'(prefix_cfg);
    endfunction

    function automatic void queue_result(input logic [nlsc_pkg::DATA_W-1:0] b,
                                         input logic last, input logic eos);
        nlsc_pkg::out_item_t r;
        r.out_byte      = b;
        r.last_of_run   = last;
        r.end_of_sample = eos;
        expected_bytes.push_back(r);
    endfunction

    function automatic void predict_item(input nlsc_pkg::in_item_t it);
        logic eos;
        if (it.first_of_sample) begin
            sample_total = it.sample_length;
            sample_left  = it.sample_length;
            restart_unit();
        end
        if (sample_left == 0) return;
        sample_left = sample_left - 1;
        eos = (sample_left == 0);

        if (!conv_on) begin
            queue_result(it.data_byte, 1'b1, eos);
        end else if (phase == GATHER_PREFIX) begin
            len_acc = {len_acc[nlsc_pkg::LEN_W-nlsc_pkg::DATA_W-1:0], it.data_byte};
            if (prefix_seen + 1 < prefix_bytes()) begin
                prefix_seen = prefix_seen + 2'd1;
            end else begin
                queue_result(nlsc_pkg::SC_ZERO_BYTE, 1'b0, 1'b0);
                queue_result(nlsc_pkg::SC_ZERO_BYTE, 1'b0, 1'b0);
                queue_result(nlsc_pkg::SC_ZERO_BYTE, 1'b0, 1'b0);
                queue_result(nlsc_pkg::SC_LAST_BYTE, 1'b1, eos);
                // bad length copies the rest, a good one is clamped to the sample
                if (len_acc == 0 || len_acc > sample_total) begin
                    phase = COPY_REST;
                end else begin
                    payload_left = (len_acc < sample_left) ? len_acc : sample_left;
                    phase = (payload_left != 0) ? COPY_PAYLOAD : GATHER_PREFIX;
                end
                prefix_seen = 2'd0;
                len_acc     = '0;
            end
        end else begin
            queue_result(it.data_byte, 1'b1, eos);
            if (phase == COPY_PAYLOAD) begin
                if (payload_left != 0) payload_left = payload_left - 1;
                if (payload_left == 0) restart_unit();
            end
        end
        if (eos) restart_unit();
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [nlsc_pkg::DATA_W-1:0] got,
                                   input logic [nlsc_pkg::DATA_W-1:0] want);
        errors++;
        if (errors <= 40) $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : watch
        nlsc_pkg::out_item_t want;
        if (!aresetn) begin
            conv_on      = 1'b1;
            prefix_cfg   = 3'd4;
            sample_left  = '0;
            sample_total = '0;
            restart_unit();
            expected_bytes.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == nlsc_pkg::CFG_CONVERT_ENABLE) conv_on = cfg_wdata[0];
                else if (cfg_index == nlsc_pkg::CFG_LENGTH_FIELD_BYTES) prefix_cfg = cfg_wdata;
            end
            if (s_valid && s_ready) predict_item(s_item);
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected item", m_item.out_byte, '0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_item.out_byte !== want.out_byte)
                        report_mismatch("out_byte", m_item.out_byte, want.out_byte);
                    if (m_item.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run",
                                        nlsc_pkg::DATA_W'(m_item.last_of_run),
                                        nlsc_pkg::DATA_W'(want.last_of_run));
                    if (m_item.end_of_sample !== want.end_of_sample)
                        report_mismatch("end_of_sample",
                                        nlsc_pkg::DATA_W'(m_item.end_of_sample),
                                        nlsc_pkg::DATA_W'(want.end_of_sample));
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_bytes.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the length-prefix to start-code converter.
// A directed run covers truncated, zero and clamped lengths, restarts and
// mid-unit register changes; random samples follow under several register
// settings with random gaps on both channels but for one quiet pass.
// ----------------------------------------------------------------------------
module tb;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic [nlsc_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [nlsc_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    nlsc_pkg::in_item_t               s_item;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    nlsc_pkg::out_item_t              m_item;
    int                               fail_count;
    int                               pending;

    logic                             quiet = 1'b0;
    logic [2:0]                       stim_prefix;
    int                               items_sent = 0;

    nal_length_prefix_to_start_code dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    nlsc_stream_checker stream_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 19);
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_byte(input logic [nlsc_pkg::DATA_W-1:0] b, input logic first,
                             input logic [nlsc_pkg::LEN_W-1:0] len);
        nlsc_pkg::in_item_t it;
        it.data_byte       = b;
        it.first_of_sample = first;
        // length is only read on the first byte, so other items carry noise
        it.sample_length   = first ? len : nlsc_pkg::LEN_W'($urandom);
        while (!quiet && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // wait until every output byte is out, then let prefix bytes settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [nlsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nlsc_pkg::CFG_DATA_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == nlsc_pkg::CFG_LENGTH_FIELD_BYTES) stim_prefix = val;
    endtask

    // mostly well-formed samples, with length and framing damage now and then
    task automatic random_sample();
        logic [nlsc_pkg::DATA_W-1:0] body[$];
        logic [nlsc_pkg::LEN_W-1:0]  total;
        logic [nlsc_pkg::LEN_W-1:0]  field;
        int                          ps;
        int                          units;
        int                          kind;
        int                          n;
        int                          k;
        ps    = (stim_prefix < 3'd1) ? 1 : (stim_prefix > 3'd4) ? 4 : int'(stim_prefix);
        units = $urandom_range(1, 4);
        kind  = $urandom_range(99);
        for (int u = 0; u < units; u++) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 6);
            field = nlsc_pkg::LEN_W'(n);
            if (kind < 8 && $urandom_range(2) == 0) field = '0;
            else if (kind >= 8 && kind < 16 && $urandom_range(2) == 0) field = $urandom;
            for (k = ps - 1; k >= 0; k--) body.push_back(nlsc_pkg::DATA_W'(field >> (8 * k)));
            repeat (n) body.push_back(nlsc_pkg::DATA_W'($urandom));
        end
        total = nlsc_pkg::LEN_W'(body.size());
        if (kind >= 16 && kind < 26) begin
            // sample ends early: cut prefixes, clamped payloads, stray bytes
            total = $urandom_range(body.size() - 1);
        end else if (kind >= 26 && kind < 34) begin
            // sample abandoned by the next first byte
            total = total + $urandom_range(1, 5);
        end else if (kind >= 34 && kind < 37) begin
            total = '0;
        end else if (kind >= 37 && kind < 40) begin
            total = '1;
        end else if (kind >= 40 && kind < 43) begin
            total = $urandom;
        end
        for (int i = 0; i < body.size(); i++) send_byte(body[i], i == 0, total);
    endtask

    initial begin : stimulus
        int target;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        stim_prefix = 3'd4;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // four-byte prefix completes exactly at the end of the sample
        send_byte(8'h00, 1'b1, 32'd4);
        send_byte(8'h00, 1'b0, '0);
        send_byte(8'h00, 1'b0, '0);
        send_byte(8'h03, 1'b0, '0);
        // prefix cut off by the sample end, then a byte outside any sample
        send_byte(8'h12, 1'b1, 32'd2);
        send_byte(8'h34, 1'b0, '0);
        send_byte(8'h5a, 1'b0, '0);

        write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES, 3'd1);
        // zero length copies the rest
        send_byte(8'h00, 1'b1, 32'd3);
        send_byte(8'hff, 1'b0, '0);
        send_byte(8'h80, 1'b0, '0);
        // length fits the sample but not the bytes left: clamped
        send_byte(8'h04, 1'b1, 32'd4);
        send_byte(8'h11, 1'b0, '0);
        send_byte(8'h22, 1'b0, '0);
        send_byte(8'h33, 1'b0, '0);
        // empty sample
        send_byte(8'h9c, 1'b1, 32'd0);
        // new sample in the middle of a payload
        send_byte(8'h03, 1'b1, 32'd5);
        send_byte(8'h44, 1'b0, '0);
        send_byte(8'h01, 1'b1, 32'd2);
        send_byte(8'hee, 1'b0, '0);

        // prefix size shrinks halfway through a prefix
        write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES, 3'd2);
        send_byte(8'h00, 1'b1, 32'd5);
        write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES, 3'd1);
        send_byte(8'h02, 1'b0, '0);
        send_byte(8'hc3, 1'b0, '0);
        send_byte(8'h3c, 1'b0, '0);
        send_byte(8'h7e, 1'b0, '0);

        // pass-through in the middle of a payload keeps the unit state
        send_byte(8'h02, 1'b1, 32'd6);
        send_byte(8'haa, 1'b0, '0);
        write_reg(nlsc_pkg::CFG_CONVERT_ENABLE, 3'd0);
        send_byte(8'hbb, 1'b0, '0);
        send_byte(8'hcc, 1'b0, '0);
        write_reg(nlsc_pkg::CFG_CONVERT_ENABLE, 3'd1);
        send_byte(8'hdd, 1'b0, '0);
        send_byte(8'h00, 1'b0, '0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES, 3'd0);
                1: write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES, 3'd7);
                2: begin
                    write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES, 3'd4);
                    write_reg(nlsc_pkg::CFG_CONVERT_ENABLE, 3'd6);
                end
                3: begin
                    write_reg(nlsc_pkg::CFG_CONVERT_ENABLE, 3'd1);
                    write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES, 3'd2);
                end
                default: begin
                    write_reg(nlsc_pkg::CFG_CONVERT_ENABLE,
                              nlsc_pkg::CFG_DATA_W'(($urandom_range(3) << 1) |
                                                    ($urandom_range(4) != 0)));
                    write_reg(nlsc_pkg::CFG_LENGTH_FIELD_BYTES,
                              nlsc_pkg::CFG_DATA_W'($urandom_range(7)));
                end
            endcase
            quiet <= (ph == 4);
            target = items_sent + 22;
            while (items_sent < target) random_sample();
        end
        quiet <= 1'b0;

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
